// ===== src/ffa_pkg.sv =====
// Shared types and constants for the first-fit free-list allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffa_pkg;

   localparam int DEF_TABLE_ENTRIES = 256;

   localparam logic [31:0] PAGE_ADD  = 32'h0000_0fff;
   localparam logic [31:0] PAGE_MASK = 32'hffff_f000;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef struct packed {
      logic [31:0] start;
      logic [31:0] length;
   } entry_type;

   typedef enum logic [1:0] {
      OP_HOLD = 2'd0,
      OP_ROT  = 2'd1,
      OP_SHR  = 2'd2,
      OP_SHL  = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        ld_head;
      logic        ld_tail;
      entry_type   head_data;
      entry_type   tail_data;
   } cell_ctrl_type;

endpackage
`default_nettype wire

// ===== src/ffa_cell.sv =====
// One table cell: holds a free region and takes a neighbor's entry on command.
`timescale 1ns / 1ps
`default_nettype none
module ffa_cell #(
   parameter int INDEX = 0,
   parameter int CW    = 9
) (
   input  wire                        clock,
   input  wire ffa_pkg::cell_op_type  op,
   input  wire  [CW-1:0]              lim,
   input  wire                        ld_en,
   input  wire ffa_pkg::entry_type    ld_data,
   input  wire ffa_pkg::entry_type    left_in,
   input  wire ffa_pkg::entry_type    right_in,
   output ffa_pkg::entry_type         q
);
   import ffa_pkg::*;

   localparam logic [CW-1:0] IDX = CW'(INDEX);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ld_en) begin
         entry_in = ld_data;
      end else begin
         unique case (op)
            OP_HOLD: entry_in = entry_ff;
            OP_ROT:  entry_in = right_in;
            // open a slot: cells up to the limit take their left neighbor
            OP_SHR: begin
               if (INDEX >= 1 && IDX <= lim) entry_in = left_in;
            end
            // close a slot: cells below the limit take their right neighbor
            OP_SHL: begin
               if (IDX < lim) entry_in = right_in;
            end
            default: entry_in = entry_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;

endmodule
`default_nettype wire

// ===== src/first_fit_free_list_allocator.sv =====
// Top level: first-fit free-list allocator built on a rotating row of table cells.
//
//   channel | ports                       | direction | handshake
//   req     | command, address, size      | in        | req_valid / req_stall
//   rsp     | grant, status, statistics   | out       | rsp_valid / rsp_stall
//   csr     | page_round                  | in        | csr_wr_en, no wait
//
// A result is loaded into the output register once its request has been worked through: the row rotates
// one entry per cycle past the head cell to the target, edits it, then rotates on to a full
// turn of TABLE_ENTRIES steps. A free joining both neighbors takes an extra edit state; when the
// scan stops at the first entry no turn is needed.
// One item is in flight; req_stall is high while it is worked on and while its result waits
// for the output register. Reset is synchronous and clears the state, page_round, counters, sums and rsp_valid.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_free_list_allocator #(
   parameter int TABLE_ENTRIES = ffa_pkg::DEF_TABLE_ENTRIES
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_wr_en,
   input  wire         csr_wr_data,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire         req_command,
   input  wire  [31:0] req_region_address,
   input  wire  [31:0] req_region_size,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [31:0] rsp_granted_address,
   output logic        rsp_status,
   output logic [31:0] rsp_free_total,
   output logic [8:0]  rsp_entry_count,
   output logic [8:0]  rsp_peak_entries,
   output logic [31:0] rsp_lost_count,
   output logic [31:0] rsp_lost_bytes
);
   import ffa_pkg::*;

   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCAN   = 6'b000010,
      ST_EDIT   = 6'b000100,
      ST_EDIT2  = 6'b001000,
      ST_ROTATE = 6'b010000,
      ST_RESP   = 6'b100000
   } state_type;

   state_type     state_ff, state_in;
   logic          page_ff, page_in;
   logic [CW-1:0] used_ff, used_in;
   logic [CW-1:0] peak_ff, peak_in;
   logic [31:0]   sum_ff, sum_in;
   logic [31:0]   lostc_ff, lostc_in;
   logic [31:0]   lostb_ff, lostb_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          cmd_ff, cmd_in;
   logic [31:0]   addr_ff, addr_in;
   logic [31:0]   size_ff, size_in;
   logic [CW-1:0] r_ff, r_in;
   logic          hit_ff, hit_in;
   logic [31:0]   granted_ff, granted_in;
   logic          status_ff, status_in;

   logic [31:0]   rsp_granted_ff, rsp_granted_in;
   logic          rsp_status_ff, rsp_status_in;
   logic [31:0]   rsp_sum_ff, rsp_sum_in;
   logic [CW-1:0] rsp_used_ff, rsp_used_in;
   logic [CW-1:0] rsp_peak_ff, rsp_peak_in;
   logic [31:0]   rsp_lostc_ff, rsp_lostc_in;
   logic [31:0]   rsp_lostb_ff, rsp_lostb_in;

   cell_ctrl_type ctrl;
   logic [CW-1:0] lim;
   entry_type     cell_q [TABLE_ENTRIES];
   entry_type     head, tail;

   logic          accept;
   logic [31:0]   new_len;
   logic          prev_ok, next_ok;

   assign head   = cell_q[0];
   assign tail   = cell_q[TABLE_ENTRIES-1];
   assign accept = req_valid && !req_stall;

   genvar gi;
   generate
      for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
         localparam int LEFT  = (gi == 0) ? TABLE_ENTRIES - 1 : gi - 1;
         localparam int RIGHT = (gi == TABLE_ENTRIES - 1) ? 0 : gi + 1;
         logic      ld_en;
         entry_type ld_data;
         if (gi == 0) begin : g_head
            assign ld_en   = ctrl.ld_head;
            assign ld_data = ctrl.head_data;
         end else if (gi == TABLE_ENTRIES - 1) begin : g_tail
            assign ld_en   = ctrl.ld_tail;
            assign ld_data = ctrl.tail_data;
         end else begin : g_mid
            assign ld_en   = 1'b0;
            assign ld_data = ctrl.head_data;
         end
         ffa_cell #(
            .INDEX (gi),
            .CW    (CW)
         ) u_cell (
            .clock    (clock),
            .op       (ctrl.op),
            .lim      (lim),
            .ld_en    (ld_en),
            .ld_data  (ld_data),
            .left_in  (cell_q[LEFT]),
            .right_in (cell_q[RIGHT]),
            .q        (cell_q[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in       = state_ff;
      page_in        = csr_wr_en ? csr_wr_data : page_ff;
      used_in        = used_ff;
      peak_in        = peak_ff;
      sum_in         = sum_ff;
      lostc_in       = lostc_ff;
      lostb_in       = lostb_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      cmd_in         = cmd_ff;
      addr_in        = addr_ff;
      size_in        = size_ff;
      r_in           = r_ff;
      hit_in         = hit_ff;
      granted_in     = granted_ff;
      status_in      = status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_sum_in     = rsp_sum_ff;
      rsp_used_in    = rsp_used_ff;
      rsp_peak_in    = rsp_peak_ff;
      rsp_lostc_in   = rsp_lostc_ff;
      rsp_lostb_in   = rsp_lostb_ff;
      ctrl.op        = OP_HOLD;
      ctrl.ld_head   = 1'b0;
      ctrl.ld_tail   = 1'b0;
      ctrl.head_data = head;
      ctrl.tail_data = tail;
      lim            = '0;
      new_len        = head.length - size_ff;
      prev_ok        = (r_ff != '0) && ((tail.start + tail.length) == addr_ff);
      next_ok        = (r_ff != used_ff) && ((addr_ff + size_ff) == head.start);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_command;
               addr_in  = req_region_address;
               size_in  = page_ff ? ((req_region_size + PAGE_ADD) & PAGE_MASK)
                                  : req_region_size;
               r_in     = '0;
               hit_in   = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (r_ff == used_ff) begin
               hit_in   = 1'b0;
               state_in = ST_EDIT;
            end else if (cmd_ff == CMD_ALLOC && head.length >= size_ff) begin
               hit_in   = 1'b1;
               state_in = ST_EDIT;
            end else if (cmd_ff == CMD_FREE && head.start > addr_ff) begin
               state_in = ST_EDIT;
            end else begin
               // advance: next entry moves into the head cell
               ctrl.op = OP_ROT;
               r_in    = r_ff + 1'b1;
            end
         end
         ST_EDIT: begin
            state_in   = ST_ROTATE;
            granted_in = '0;
            status_in  = STATUS_OK;
            if (cmd_ff == CMD_ALLOC) begin
               if (hit_ff) begin
                  granted_in = head.start;
                  sum_in     = sum_ff - size_ff;
                  if (new_len == '0) begin
                     ctrl.op = OP_SHL;
                     lim     = used_ff - r_ff - 1'b1;
                     used_in = used_ff - 1'b1;
                  end else begin
                     ctrl.ld_head   = 1'b1;
                     ctrl.head_data = '{start: head.start + size_ff, length: new_len};
                  end
               end else begin
                  status_in = STATUS_FAIL;
               end
            end else if (prev_ok) begin
               ctrl.ld_tail   = 1'b1;
               ctrl.tail_data = '{start: tail.start, length: tail.length + size_ff};
               sum_in         = sum_ff + size_ff;
               if (next_ok) state_in = ST_EDIT2;
            end else if (next_ok) begin
               ctrl.ld_head   = 1'b1;
               ctrl.head_data = '{start: addr_ff, length: head.length + size_ff};
               sum_in         = sum_ff + size_ff;
            end else if (used_ff != FULL) begin
               // open a slot at the head and drop the new region into it
               ctrl.op        = OP_SHR;
               lim            = used_ff - r_ff;
               ctrl.ld_head   = 1'b1;
               ctrl.head_data = '{start: addr_ff, length: size_ff};
               used_in        = used_ff + 1'b1;
               if (used_ff + 1'b1 > peak_ff) peak_in = used_ff + 1'b1;
               sum_in         = sum_ff + size_ff;
            end else begin
               status_in = STATUS_FAIL;
               lostc_in  = lostc_ff + 32'd1;
               lostb_in  = lostb_ff + size_ff;
            end
         end
         ST_EDIT2: begin
            // fold the upper neighbor into the lower one and drop it
            ctrl.ld_tail   = 1'b1;
            ctrl.tail_data = '{start: tail.start, length: tail.length + head.length};
            ctrl.op        = OP_SHL;
            lim            = used_ff - r_ff - 1'b1;
            used_in        = used_ff - 1'b1;
            state_in       = ST_ROTATE;
         end
         ST_ROTATE: begin
            if (r_ff == '0 || r_ff == FULL) begin
               state_in = ST_RESP;
            end else begin
               ctrl.op = OP_ROT;
               r_in    = r_ff + 1'b1;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = granted_ff;
               rsp_status_in  = status_ff;
               rsp_sum_in     = sum_ff;
               rsp_used_in    = used_ff;
               rsp_peak_in    = peak_ff;
               rsp_lostc_in   = lostc_ff;
               rsp_lostb_in   = lostb_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         page_ff      <= 1'b0;
         used_ff      <= '0;
         peak_ff      <= '0;
         sum_ff       <= '0;
         lostc_ff     <= '0;
         lostb_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         page_ff      <= page_in;
         used_ff      <= used_in;
         peak_ff      <= peak_in;
         sum_ff       <= sum_in;
         lostc_ff     <= lostc_in;
         lostb_ff     <= lostb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      addr_ff        <= addr_in;
      size_ff        <= size_in;
      r_ff           <= r_in;
      hit_ff         <= hit_in;
      granted_ff     <= granted_in;
      status_ff      <= status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_sum_ff     <= rsp_sum_in;
      rsp_used_ff    <= rsp_used_in;
      rsp_peak_ff    <= rsp_peak_in;
      rsp_lostc_ff   <= rsp_lostc_in;
      rsp_lostb_ff   <= rsp_lostb_in;
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_granted_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_free_total      = rsp_sum_ff;
   assign rsp_entry_count     = 9'(rsp_used_ff);
   assign rsp_peak_entries    = 9'(rsp_peak_ff);
   assign rsp_lost_count      = rsp_lostc_ff;
   assign rsp_lost_bytes      = rsp_lostb_ff;

endmodule
`default_nettype wire

// ===== sim/first_fit_free_list_allocator_checker.sv =====
// Transfer monitor, allocator table predictor and result comparator.
`timescale 1ns / 1ps
module first_fit_free_list_allocator_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_wr_en,
   input  wire         csr_wr_data,
   input  wire         req_valid,
   input  wire         req_stall,
   input  wire         req_command,
   input  wire  [31:0] req_region_address,
   input  wire  [31:0] req_region_size,
   input  wire         rsp_valid,
   input  wire         rsp_stall,
   input  wire  [31:0] rsp_granted_address,
   input  wire         rsp_status,
   input  wire  [31:0] rsp_free_total,
   input  wire  [8:0]  rsp_entry_count,
   input  wire  [8:0]  rsp_peak_entries,
   input  wire  [31:0] rsp_lost_count,
   input  wire  [31:0] rsp_lost_bytes,
   output int          mismatches,
   output int          pending,
   output int          drops_seen,
   output int          peak_seen
);
   import ffa_pkg::*;

   localparam int DEPTH = DEF_TABLE_ENTRIES;

   typedef struct {
      logic [31:0] grant;
      logic        status;
      logic [31:0] free_sum;
      logic [8:0]  entries;
      logic [8:0]  peak;
      logic [31:0] lost_n;
      logic [31:0] lost_sum;
   } alloc_result_type;

   logic [31:0]      free_start [DEPTH];
   logic [31:0]      free_len   [DEPTH];
   int               held;
   int               most_held;
   logic [31:0]      dropped_n;
   logic [31:0]      dropped_sum;
   logic [31:0]      free_sum;
   logic             round_pages;
   alloc_result_type expected_q[$];
   int               printed;

   task automatic report(input string what);
      mismatches++;
      if (printed < 40) begin
         printed++;
         $display("[%0t] ERROR: %s", $realtime, what);
      end
   endtask

   function automatic void drop_entry(input int k);
      held--;
      for (int m = k; m < held; m++) begin
         free_start[m] = free_start[m + 1];
         free_len[m]   = free_len[m + 1];
      end
   endfunction

   function automatic alloc_result_type predict_alloc_free(input logic cmd,
         input logic [31:0] addr, input logic [31:0] size_in);
      alloc_result_type r;
      logic [31:0]      size;
      logic             ok;
      int               k;
      size    = round_pages ? ((size_in + PAGE_ADD) & PAGE_MASK) : size_in;
      r.grant = '0;
      ok      = 1'b0;
      if (cmd == CMD_ALLOC) begin
         for (k = 0; k < held; k++) begin
            if (free_len[k] >= size) begin
               r.grant       = free_start[k];
               free_start[k] = free_start[k] + size;
               free_len[k]   = free_len[k] - size;
               free_sum      = free_sum - size;
               if (free_len[k] == 0) drop_entry(k);
               ok = 1'b1;
               break;
            end
         end
      end else begin
         for (k = 0; k < held; k++)
            if (free_start[k] > addr) break;
         if (k > 0 && free_start[k-1] + free_len[k-1] == addr) begin
            free_len[k-1] = free_len[k-1] + size;
            free_sum      = free_sum + size;
            if (k < held && addr + size == free_start[k]) begin
               free_len[k-1] = free_len[k-1] + free_len[k];
               drop_entry(k);
            end
            ok = 1'b1;
         end else if (k < held && addr + size == free_start[k]) begin
            free_start[k] = addr;
            free_len[k]   = free_len[k] + size;
            free_sum      = free_sum + size;
            ok = 1'b1;
         end else if (held < DEPTH) begin
            for (int m = held; m > k; m--) begin
               free_start[m] = free_start[m-1];
               free_len[m]   = free_len[m-1];
            end
            held++;
            if (most_held < held) most_held = held;
            free_start[k] = addr;
            free_len[k]   = size;
            free_sum      = free_sum + size;
            ok = 1'b1;
         end else begin
            dropped_n   = dropped_n + 1;
            dropped_sum = dropped_sum + size;
         end
      end
      r.status   = ok ? STATUS_OK : STATUS_FAIL;
      r.free_sum = free_sum;
      r.entries  = held[8:0];
      r.peak     = most_held[8:0];
      r.lost_n   = dropped_n;
      r.lost_sum = dropped_sum;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] got,
         input logic [31:0] want);
      if (got !== want)
         report($sformatf("%s got %h expected %h", name, got, want));
   endtask

   initial begin
      mismatches = 0;
      pending    = 0;
      drops_seen = 0;
      peak_seen  = 0;
      printed    = 0;
   end

   always @(posedge clock) begin
      alloc_result_type want;
      if (reset) begin
         held        = 0;
         most_held   = 0;
         dropped_n   = '0;
         dropped_sum = '0;
         free_sum    = '0;
         round_pages = 1'b0;
         expected_q.delete();
      end else begin
         if (csr_wr_en) round_pages = csr_wr_data;
         if (req_valid && !req_stall)
            expected_q.push_back(predict_alloc_free(req_command, req_region_address,
                                                    req_region_size));
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               report("result transfer with nothing outstanding");
            end else begin
               want = expected_q.pop_front();
               check_field("granted_address", rsp_granted_address, want.grant);
               check_field("status", {31'b0, rsp_status}, {31'b0, want.status});
               check_field("free_total", rsp_free_total, want.free_sum);
               check_field("entry_count", {23'b0, rsp_entry_count}, {23'b0, want.entries});
               check_field("peak_entries", {23'b0, rsp_peak_entries}, {23'b0, want.peak});
               check_field("lost_count", rsp_lost_count, want.lost_n);
               check_field("lost_bytes", rsp_lost_bytes, want.lost_sum);
            end
         end
      end
      pending    <= expected_q.size();
      drops_seen <= dropped_n;
      peak_seen  <= most_held;
   end

endmodule

// ===== sim/first_fit_free_list_allocator_tb.sv =====
// Stimulus, clocking and verdict for the first-fit free-list allocator.
`timescale 1ns / 1ps
module first_fit_free_list_allocator_tb;
   import ffa_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_wr_data;
   logic        req_valid;
   logic        req_stall;
   logic        req_command;
   logic [31:0] req_region_address;
   logic [31:0] req_region_size;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_granted_address;
   logic        rsp_status;
   logic [31:0] rsp_free_total;
   logic [8:0]  rsp_entry_count;
   logic [8:0]  rsp_peak_entries;
   logic [31:0] rsp_lost_count;
   logic [31:0] rsp_lost_bytes;
   int          mismatches;
   int          pending;
   int          drops_seen;
   int          peak_seen;
   bit          sender_gaps;
   bit          receiver_gaps;
   bit          hold_req;
   int          sent;
   logic [31:0] region_base;

   first_fit_free_list_allocator uut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_region_address(req_region_address), .req_region_size(req_region_size),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_granted_address(rsp_granted_address), .rsp_status(rsp_status),
      .rsp_free_total(rsp_free_total), .rsp_entry_count(rsp_entry_count),
      .rsp_peak_entries(rsp_peak_entries), .rsp_lost_count(rsp_lost_count),
      .rsp_lost_bytes(rsp_lost_bytes)
   );

   first_fit_free_list_allocator_checker u_checker (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_region_address(req_region_address), .req_region_size(req_region_size),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_granted_address(rsp_granted_address), .rsp_status(rsp_status),
      .rsp_free_total(rsp_free_total), .rsp_entry_count(rsp_entry_count),
      .rsp_peak_entries(rsp_peak_entries), .rsp_lost_count(rsp_lost_count),
      .rsp_lost_bytes(rsp_lost_bytes),
      .mismatches(mismatches), .pending(pending),
      .drops_seen(drops_seen), .peak_seen(peak_seen)
   );

   always #6 clock = ~clock;

   initial begin
      #60ms;
      $display("timeout waiting for transfers");
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // receiver: random stalls, or one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (3000) @(posedge clock);
            hold_req = 1'b0;
         end else begin
            rsp_stall <= receiver_gaps && ($urandom_range(99) < 9);
         end
      end
   end

   task automatic send_request(input logic cmd, input logic [31:0] addr,
         input logic [31:0] size);
      if (sender_gaps && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= cmd;
      req_region_address <= addr;
      req_region_size    <= size;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   // lower valid and wait until every outstanding result is back
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (270) @(posedge clock);
   endtask

   task automatic write_page_round(input logic value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic random_request;
      int pick;
      pick = $urandom_range(99);
      if (pick < 55)
         // page-granular frees near a base so neighbors touch often
         send_request(CMD_FREE, region_base + ($urandom_range(511) << 12),
                      $urandom_range(1, 3) << 12);
      else if (pick < 65)
         send_request(CMD_FREE, region_base + $urandom_range(32'h1f_ffff),
                      $urandom_range(32'h2fff));
      else if (pick < 90)
         send_request(CMD_ALLOC, $urandom, $urandom_range(32'h4000));
      else
         send_request(1'($urandom_range(1)), $urandom, $urandom);
   endtask

   task automatic random_phase(input int count, input bit with_hold);
      for (int i = 0; i < count; i++) begin
         if (i % 200 == 0) region_base = $urandom & PAGE_MASK;
         if (with_hold && i == count / 2) hold_req = 1'b1;
         random_request();
      end
   endtask

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = 1'b0;
      req_valid          = 1'b0;
      req_command        = CMD_ALLOC;
      req_region_address = '0;
      req_region_size    = '0;
      rsp_stall          = 1'b0;
      sender_gaps        = 1'b1;
      receiver_gaps      = 1'b1;
      hold_req           = 1'b0;
      sent               = 0;
      region_base        = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_page_round(1'b0);

      // empty table, joins both ways, wrap, zero sizes, full-range fields
      send_request(CMD_ALLOC, 32'hffff_ffff, 32'h0);
      send_request(CMD_FREE, 32'h0, 32'h1000);
      send_request(CMD_ALLOC, 32'h0, 32'h800);
      send_request(CMD_ALLOC, 32'h0, 32'h800);
      send_request(CMD_FREE, 32'h5000, 32'h1000);
      send_request(CMD_FREE, 32'h6000, 32'h1000);
      send_request(CMD_FREE, 32'h4000, 32'h1000);
      send_request(CMD_FREE, 32'h8000, 32'h1000);
      send_request(CMD_FREE, 32'h7000, 32'h1000);
      send_request(CMD_FREE, 32'h2_0000, 32'h0);
      send_request(CMD_ALLOC, 32'h0, 32'h0);
      send_request(CMD_FREE, 32'hffff_f000, 32'h1000);
      send_request(CMD_FREE, 32'h0, 32'h100);
      send_request(CMD_ALLOC, 32'h0, 32'hffff_ffff);
      send_request(CMD_FREE, 32'h8000_0000, 32'hffff_ffff);
      send_request(CMD_ALLOC, 32'hffff_ffff, 32'h7fff_ffff);
      send_request(CMD_FREE, 32'h4000, 32'h1000);
      send_request(CMD_ALLOC, 32'h0, 32'h1);
      drain();
      write_page_round(1'b1);
      send_request(CMD_ALLOC, 32'h0, 32'hffff_f001);
      send_request(CMD_FREE, 32'h10_0000, 32'h1);
      send_request(CMD_ALLOC, 32'h0, 32'h1);
      send_request(CMD_FREE, 32'h20_0000, 32'hffff_ffff);
      random_phase(500, 1'b1);
      drain();

      write_page_round(1'b0);
      // fill the table with separated regions until frees are dropped
      sender_gaps   = 1'b0;
      receiver_gaps = 1'b0;
      for (int i = 0; i < 270; i++)
         send_request(CMD_FREE, 32'h4000_0000 + (i << 13), 32'h1000 + i);
      for (int i = 0; i < 30; i++)
         send_request(CMD_ALLOC, 32'h0, 32'h1000 + $urandom_range(40));
      sender_gaps   = 1'b1;
      receiver_gaps = 1'b1;
      random_phase(400, 1'b0);
      drain();

      write_page_round(1'b1);
      random_phase(200, 1'b0);
      drain();
      write_page_round(1'b0);
      random_phase(200, 1'b1);
      drain();

      $display("covered %0d transfers with page rounding off and on", sent);
      $display("table peak %0d entries, %0d frees dropped on a full table",
               peak_seen, drops_seen);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
